/* hw/rtl/block_crc32_verify_store_top_assert.svh */
// Assertion macros for the checker file of the checksum verify store.
`ifndef BLOCK_CRC32_VERIFY_STORE_TOP_ASSERT_SVH
`define BLOCK_CRC32_VERIFY_STORE_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define BCVS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication that must hold in the following cycle.
`define BCVS_ASSERT_NEXT(lbl, pre, post, msg) \
	`BCVS_ASSERT(lbl, (pre) |=> (post), msg)

`endif

/* hw/rtl/bcvs_pkg.sv */
// Package: beat types, CRC constants and the byte-wide CRC-32 step.
`timescale 1ns / 1ps

package bcvs_pkg;

	localparam int SLOT_W  = 4;
	localparam int BLK_W   = 10;
	localparam int CRC_W   = 32;
	localparam int SLOT_SPAN = 1 << SLOT_W;
	localparam int BLK_SPAN  = 1 << BLK_W;

	localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] chunk_slot;
		logic [BLK_W-1:0]  block_number;
		logic [CRC_W-1:0]  checksum_value;
		logic [7:0]        data_byte;
		logic              byte_present;
		logic              last_byte;
	} item_t;

	typedef struct packed {
		logic             matched;
		logic             entry_absent;
		logic [CRC_W-1:0] computed_crc;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [BLK_W-1:0]  blk;
		logic [CRC_W-1:0]  data;
	} store_wr_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [BLK_W-1:0]  blk;
	} store_rd_t;

	// Reflected CRC-32, one byte folded in eight shift/xor steps.
	function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc_in,
			input logic [7:0] byte_in);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {24'h0, byte_in};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hw/rtl/bcvs_store.sv */
// Checksum table with its reset clearing pass, and the per-slot known block counts.
`timescale 1ns / 1ps

module bcvs_store #(
	parameter int SLOTS  = 16,
	parameter int BLOCKS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bcvs_pkg::store_wr_t wr,
	input  bcvs_pkg::store_rd_t rd,
	output logic                absent,
	output logic [31:0]         rdata_q,
	output logic                busy
);
	import bcvs_pkg::*;

	localparam int DEPTH  = SLOTS * BLOCKS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(BLOCKS + 1);

	logic [CRC_W-1:0] mem [DEPTH];
	logic [CNT_W-1:0] cnt_q [SLOTS];
	logic [ADDR_W-1:0] clr_q;
	logic busy_q;

	logic wr_in_range, rd_in_range;
	logic [ADDR_W-1:0] wr_addr, rd_addr, mem_addr;
	logic [CRC_W-1:0] mem_wdata;
	logic mem_we;
	logic [SIDX_W-1:0] wr_sidx, rd_sidx;
	logic [CNT_W-1:0] wr_cnt, rd_cnt, wr_cnt_new;

	assign wr_in_range = (int'(wr.slot) < SLOTS) && (int'(wr.blk) < BLOCKS);
	assign rd_in_range = (int'(rd.slot) < SLOTS) && (int'(rd.blk) < BLOCKS);
	assign wr_addr = ADDR_W'(int'(wr.slot) * BLOCKS + int'(wr.blk));
	assign rd_addr = ADDR_W'(int'(rd.slot) * BLOCKS + int'(rd.blk));
	assign wr_sidx = wr.slot[SIDX_W-1:0];
	assign rd_sidx = rd.slot[SIDX_W-1:0];
	assign wr_cnt  = wr_in_range ? cnt_q[wr_sidx] : '0;
	assign rd_cnt  = rd_in_range ? cnt_q[rd_sidx] : '0;
	assign wr_cnt_new = CNT_W'({1'b0, wr.blk} + (BLK_W+1)'(1));

	assign absent = !rd_in_range || ({1'b0, rd.blk} >= (BLK_W+1)'(rd_cnt));

	// clearing pass owns the write port after reset
	assign mem_we    = busy_q || (wr.en && wr_in_range);
	assign mem_addr  = busy_q ? clr_q : wr_addr;
	assign mem_wdata = busy_q ? '0 : wr.data;
	assign busy      = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + ADDR_W'(1);
			if (clr_q == ADDR_W'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (wr.en && wr_in_range && (wr_cnt < wr_cnt_new)) begin
			cnt_q[wr_sidx] <= wr_cnt_new;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/block_crc32_verify_store_top.sv */
// Top level: stores per-block CRC-32 values and verifies streamed blocks against them.
//
// Input channel item/item_valid/item_ready: one beat is either a checksum update
// (kind 0: writes chunk_slot/block_number and raises that slot's known count) or
// one verify byte (kind 1). Verify beats fold data_byte into a reflected CRC-32
// when byte_present is set; the beat with last_byte set ends the block and its
// chunk_slot/block_number pick the stored entry to compare.
// Output channel result/result_valid/result_ready: one beat per last verify beat,
// with matched, entry_absent and the final CRC (0 for an empty block).
// Throughput: one beat per cycle on the input, set by the single byte-wide CRC
// step and the one-port table (one write or one read per cycle), while no result
// stalls and the table is not clearing. result_valid rises once the last verify
// beat has passed the input register, then the table read register.
// Reset: counts clear at once; the table is swept to zero, one entry a cycle,
// over all CHUNK_SLOTS*BLOCKS_PER_CHUNK entries (16384 at the defaults, capped by
// the field ranges) with item_ready low.
// Stall: a waiting result holds; one more beat is still taken into the input
// register, and beats that give no result keep flowing behind it.
`timescale 1ns / 1ps

module block_crc32_verify_store_top #(
	parameter int CHUNK_SLOTS      = 16,
	parameter int BLOCKS_PER_CHUNK = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  bcvs_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output bcvs_pkg::result_t result
);
	import bcvs_pkg::*;

	// only entries the field widths can reach get storage
	localparam int EFF_SLOTS  = (CHUNK_SLOTS < SLOT_SPAN) ? CHUNK_SLOTS : SLOT_SPAN;
	localparam int EFF_BLOCKS = (BLOCKS_PER_CHUNK < BLK_SPAN) ? BLOCKS_PER_CHUNK : BLK_SPAN;

	item_t            item_s1;
	logic             valid_s1;
	logic             valid_s2;
	logic             absent_s2;
	logic [CRC_W-1:0] crc_s2;
	logic [CRC_W-1:0] running_crc_q;
	logic [CRC_W-1:0] folded;
	logic [CRC_W-1:0] rdata_s2;
	logic             res_s1, go_s1, busy, absent_s1;
	store_wr_t        wr;
	store_rd_t        rd;

	assign res_s1 = (item_s1.kind == KIND_DATA) && item_s1.last_byte;
	assign go_s1  = valid_s1 && (!res_s1 || !valid_s2 || result_ready);
	assign item_ready = !busy && (!valid_s1 || go_s1);

	assign folded = item_s1.byte_present ? crc_fold_byte(running_crc_q, item_s1.data_byte)
		: running_crc_q;

	assign wr.en   = go_s1 && (item_s1.kind == KIND_UPDATE);
	assign wr.slot = item_s1.chunk_slot;
	assign wr.blk  = item_s1.block_number;
	assign wr.data = item_s1.checksum_value;
	assign rd.en   = go_s1 && res_s1;
	assign rd.slot = item_s1.chunk_slot;
	assign rd.blk  = item_s1.block_number;

	bcvs_store #(
		.SLOTS  (EFF_SLOTS),
		.BLOCKS (EFF_BLOCKS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.absent  (absent_s1),
		.rdata_q (rdata_s2),
		.busy    (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= CRC_INIT;
		end else if (go_s1 && (item_s1.kind == KIND_DATA)) begin
			running_crc_q <= item_s1.last_byte ? CRC_INIT : folded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rd.en) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			absent_s2 <= absent_s1;
			crc_s2    <= ~folded;
		end
	end

	assign result_valid        = valid_s2;
	assign result.entry_absent = absent_s2;
	assign result.computed_crc = crc_s2;
	assign result.matched      = !absent_s2 && (rdata_s2 == crc_s2);

endmodule

/* hw/rtl/bcvs_checker.sv */
// Port-level checker for the checksum verify store, bound to the top level.
`timescale 1ns / 1ps
`include "block_crc32_verify_store_top_assert.svh"

module bcvs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input bcvs_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input bcvs_pkg::result_t result
);
	import bcvs_pkg::*;

	`BCVS_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid, "result beat dropped before accept")
	`BCVS_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(result), "stalled result beat changed")
	// a fresh result traces back to an accepted last verify beat
	`BCVS_ASSERT(a_result_source, $rose(result_valid) |-> $past(item_valid && item_ready && (item.kind == KIND_DATA) && item.last_byte, 2), "result without a last verify beat")

endmodule

bind block_crc32_verify_store_top bcvs_checker u_checker (.*);
